// ===== hw/rtl/dws_pkg.sv =====
// ============================================================================
// dws_pkg: shared types and codes of the deadline window supervisor
// Holds event, status and reason codes, register indexes and the structs
// that travel between the supervisor's modules.
// ============================================================================
package dws_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned FuncW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ReasonW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 64;

  // Event codes
  localparam logic [FuncW-1:0] EV_SOURCE = 4'd0;
  localparam logic [FuncW-1:0] EV_TARGET = 4'd1;
  localparam logic [FuncW-1:0] EV_OTHER  = 4'd2;
  localparam logic [FuncW-1:0] EV_SYNC   = 4'd3;
  localparam logic [FuncW-1:0] EV_ACT    = 4'd4;
  localparam logic [FuncW-1:0] EV_DEACT  = 4'd5;
  localparam logic [FuncW-1:0] EV_RECOV  = 4'd6;
  localparam logic [FuncW-1:0] EV_RING   = 4'd7;
  localparam logic [FuncW-1:0] EV_HIST   = 4'd8;

  // Status codes
  localparam logic [StatusW-1:0] ST_DEACT = 2'd0;
  localparam logic [StatusW-1:0] ST_OK    = 2'd1;
  localparam logic [StatusW-1:0] ST_EXP   = 2'd2;

  // Reason codes
  localparam logic [ReasonW-1:0] RS_OK     = 3'd0;
  localparam logic [ReasonW-1:0] RS_DEACT  = 3'd1;
  localparam logic [ReasonW-1:0] RS_DOUBLE = 3'd2;
  localparam logic [ReasonW-1:0] RS_MAX    = 3'd3;
  localparam logic [ReasonW-1:0] RS_MIN    = 3'd4;
  localparam logic [ReasonW-1:0] RS_RING   = 3'd5;
  localparam logic [ReasonW-1:0] RS_HIST   = 3'd6;
  localparam logic [ReasonW-1:0] RS_DATA   = 3'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_WINDOW    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_WINDOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_CHECK_OFF = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHECK_OFF = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0] min_window;
    logic [TimeW-1:0] max_window;
    logic             min_check_off;
    logic             max_check_off;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ReasonW-1:0] reason;
    logic [TimeW-1:0]   event_time;
    logic               changed;
  } res_t;

endpackage

// ===== hw/rtl/dws_ev_if.sv =====
// ============================================================================
// dws_ev_if: event input channel
// Carries one event code and its time stamp per transaction.
// ============================================================================
interface dws_ev_if;
  logic                         valid;
  logic                         ready;
  logic [dws_pkg::FuncW-1:0]    func;
  logic [dws_pkg::TimeW-1:0]    stamp;

  modport source (output valid, func, stamp, input ready);
  modport sink   (input valid, func, stamp, output ready);
endinterface

// ===== hw/rtl/dws_res_if.sv =====
// ============================================================================
// dws_res_if: result output channel
// Carries status, reason, event time and the change flag per transaction.
// ============================================================================
interface dws_res_if;
  logic                         valid;
  logic                         ready;
  logic [dws_pkg::StatusW-1:0]  status;
  logic [dws_pkg::ReasonW-1:0]  reason;
  logic [dws_pkg::TimeW-1:0]    event_time;
  logic                         changed;

  modport source (output valid, status, reason, event_time, changed, input ready);
  modport sink   (input valid, status, reason, event_time, changed, output ready);
endinterface

// ===== hw/rtl/dws_cfg_if.sv =====
// ============================================================================
// dws_cfg_if: configuration write channel
// Carries a register index and write data per transaction.
// ============================================================================
interface dws_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dws_pkg::CfgIdxW-1:0]   index;
  logic [dws_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dws_cfg_regs.sv =====
// ============================================================================
// dws_cfg_regs: configuration register file
// Decodes writes on the configuration channel into the window registers.
// ============================================================================
module dws_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  dws_cfg_if.sink       cfg_i,
  output dws_pkg::cfg_t cfg_o
);

  dws_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        dws_pkg::REG_MIN_WINDOW:    cfg_d.min_window    = cfg_i.data;
        dws_pkg::REG_MAX_WINDOW:    cfg_d.max_window    = cfg_i.data;
        dws_pkg::REG_MIN_CHECK_OFF: cfg_d.min_check_off = cfg_i.data[0];
        dws_pkg::REG_MAX_CHECK_OFF: cfg_d.max_check_off = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/dws_core.sv =====
// ============================================================================
// dws_core: event register, supervision state and next-state logic
// Registers one event, then applies it to the supervision state once the
// output register is ready, and presents the result to that register.
// ============================================================================
module dws_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  dws_ev_if.sink        ev_i,
  input  dws_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dws_pkg::res_t res_o
);

  localparam int unsigned TW = dws_pkg::TimeW;

  // Event register
  logic                      ev_valid_q;
  logic [dws_pkg::FuncW-1:0] func_q;
  logic [TW-1:0]             stamp_q;
  logic                      adv;

  // Supervision state
  logic [dws_pkg::StatusW-1:0] status_q, status_d;
  logic [dws_pkg::ReasonW-1:0] reason_q, reason_d;
  logic [TW-1:0]               src_q, src_d;
  logic [TW-1:0]               evt_q, evt_d;
  logic [TW-1:0]               sync_q, sync_d;
  logic                        loss_q, loss_d;
  logic                        rep;

  logic [TW-1:0] gap;
  logic [TW-1:0] max_miss_time;
  logic          src_set;
  logic          max_hit;
  logic          min_hit;

  assign adv         = ev_valid_q && res_ready_i;
  assign ev_i.ready  = !ev_valid_q || res_ready_i;
  assign res_valid_o = ev_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (ev_i.ready) begin
      ev_valid_q <= ev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.valid && ev_i.ready) begin
      func_q  <= ev_i.func;
      stamp_q <= ev_i.stamp;
    end
  end

  // Gap checks against the window registers
  assign src_set       = (src_q != '0);
  assign gap           = stamp_q - src_q;
  assign max_hit       = !cfg_i.max_check_off && (gap > cfg_i.max_window);
  assign min_hit       = !cfg_i.min_check_off && (gap < cfg_i.min_window);
  assign max_miss_time = src_q + cfg_i.max_window + TW'(1);

  always_comb begin
    status_d = status_q;
    reason_d = reason_q;
    src_d    = src_q;
    evt_d    = evt_q;
    sync_d   = sync_q;
    loss_d   = loss_q;
    rep      = 1'b0;

    if (func_q == dws_pkg::EV_RING || func_q == dws_pkg::EV_HIST) begin
      // Hold the loss until the next sync tick
      loss_d   = 1'b1;
      reason_d = (func_q == dws_pkg::EV_RING) ? dws_pkg::RS_RING : dws_pkg::RS_HIST;
      evt_d    = sync_q;
    end else if (func_q > dws_pkg::EV_HIST) begin
      // Unknown code: drop
    end else if (loss_q) begin
      if (func_q == dws_pkg::EV_SYNC) begin
        if (status_q != dws_pkg::ST_EXP) begin
          status_d = dws_pkg::ST_EXP;
          src_d    = '0;
          rep      = 1'b1;
        end
        loss_d = 1'b0;
        sync_d = stamp_q;
      end
    end else begin
      case (status_q)
        dws_pkg::ST_DEACT: begin
          if (func_q == dws_pkg::EV_ACT) begin
            evt_d    = stamp_q;
            status_d = dws_pkg::ST_OK;
            reason_d = dws_pkg::RS_OK;
            rep      = 1'b1;
          end
        end
        dws_pkg::ST_OK: begin
          case (func_q)
            dws_pkg::EV_SOURCE: begin
              if (src_set) begin
                reason_d = dws_pkg::RS_DOUBLE;
                evt_d    = stamp_q;
                src_d    = '0;
              end else begin
                src_d = stamp_q;
              end
            end
            dws_pkg::EV_TARGET: begin
              evt_d = stamp_q;
              if (src_set) begin
                src_d = '0;
                if (max_hit) begin
                  reason_d = dws_pkg::RS_MAX;
                  evt_d    = max_miss_time;
                end else begin
                  reason_d = min_hit ? dws_pkg::RS_MIN : dws_pkg::RS_OK;
                end
              end
            end
            dws_pkg::EV_OTHER: begin
            end
            default: begin
              if (src_set && max_hit) begin
                reason_d = dws_pkg::RS_MAX;
                evt_d    = max_miss_time;
                src_d    = '0;
              end
            end
          endcase
          if (reason_d != dws_pkg::RS_OK) begin
            status_d = dws_pkg::ST_EXP;
            loss_d   = 1'b0;
            src_d    = '0;
            rep      = 1'b1;
          end
        end
        dws_pkg::ST_EXP: begin
        end
        default: begin
          // Corrupt status code: flag a data error
          evt_d    = sync_q;
          reason_d = dws_pkg::RS_DATA;
          status_d = dws_pkg::ST_EXP;
          loss_d   = 1'b0;
          src_d    = '0;
          rep      = 1'b1;
        end
      endcase

      if (func_q == dws_pkg::EV_RECOV) begin
        // Deactivate, then reactivate at the stamp
        src_d    = '0;
        evt_d    = stamp_q;
        status_d = dws_pkg::ST_OK;
        reason_d = dws_pkg::RS_OK;
        rep      = 1'b1;
      end else if (func_q == dws_pkg::EV_DEACT && status_d != dws_pkg::ST_DEACT) begin
        evt_d    = stamp_q;
        status_d = dws_pkg::ST_DEACT;
        reason_d = dws_pkg::RS_DEACT;
        src_d    = '0;
        rep      = 1'b1;
      end

      if (func_q == dws_pkg::EV_SYNC) begin
        sync_d = stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= dws_pkg::ST_DEACT;
      reason_q <= dws_pkg::RS_OK;
      src_q    <= '0;
      evt_q    <= '0;
      sync_q   <= '0;
      loss_q   <= 1'b0;
    end else if (adv) begin
      status_q <= status_d;
      reason_q <= reason_d;
      src_q    <= src_d;
      evt_q    <= evt_d;
      sync_q   <= sync_d;
      loss_q   <= loss_d;
    end
  end

  assign res_o.status     = status_d;
  assign res_o.reason     = reason_d;
  assign res_o.event_time = evt_d;
  assign res_o.changed    = rep;

  // A pending source only exists while supervision is ok
  a_src_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_q != '0 |-> status_q == dws_pkg::ST_OK)
    else $error("source time held outside ok status");

  // A pending loss always carries a loss reason
  a_loss_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    loss_q |-> (reason_q == dws_pkg::RS_RING || reason_q == dws_pkg::RS_HIST))
    else $error("loss pending without loss reason");

  // A reported ok status has reason ok
  a_ok_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && rep && status_d == dws_pkg::ST_OK) |-> reason_d == dws_pkg::RS_OK)
    else $error("ok status reported with a fault reason");

  // State moves only when an event is applied
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(status_q) && $stable(loss_q) && $stable(src_q))
    else $error("state changed without an applied event");

endmodule

// ===== hw/rtl/dws_out_reg.sv =====
// ============================================================================
// dws_out_reg: result register
// Holds one result until the output channel takes it.
// ============================================================================
module dws_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  dws_pkg::res_t res_i,
  dws_res_if.source     res_o
);

  logic          valid_q;
  dws_pkg::res_t res_q;

  assign res_ready_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.status     = res_q.status;
  assign res_o.reason     = res_q.reason;
  assign res_o.event_time = res_q.event_time;
  assign res_o.changed    = res_q.changed;

endmodule

// ===== hw/rtl/deadline_window_supervisor_top.sv =====
// Path: an event passes the event register, then the result register, before
//   its result transaction; the state is applied as the result register takes it.
// Throughput: one event per cycle while the result register drains or is empty;
//   the supervision state updates on each applied event through one 64-bit
//   subtract, two compares and the state decode.
// Reset: rst_ni is asynchronous, active low; status comes up deactivated,
//   the supervision times and the window registers clear to zero.
// ============================================================================
// deadline_window_supervisor_top: deadline window supervisor
// Checks that each source checkpoint is followed by a target checkpoint
// inside the configured window and reports status transitions.
// ============================================================================
module deadline_window_supervisor_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dws_ev_if.sink    ev_i,
  dws_res_if.source res_o,
  dws_cfg_if.sink   cfg_i
);

  // Window configuration; only write while no event is in flight, not enforced
  dws_pkg::cfg_t cfg;

  // Core to result register: one result per applied event
  logic          res_valid;
  logic          res_ready;
  dws_pkg::res_t res;

  dws_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Register the event, then apply it to the supervision state when results drain
  dws_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Hold the result while the consumer stalls; the core keeps accepting
  // as long as this register drains or is empty
  dws_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .res_o       (res_o)
  );

endmodule
